// ===== rtl/tridiagonal_thomas_solver_macros.svh =====
// Assertion macros for the tridiagonal solver, clocked on clk with reset arst_n.
`ifndef TRIDIAGONAL_THOMAS_SOLVER_MACROS_SVH
`define TRIDIAGONAL_THOMAS_SOLVER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TTS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tts assertion failed");
`define TTS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tts assertion failed");
`else
`define TTS_ASSERT_IMP(lbl, ante, cons)
`define TTS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/tts_pkg.sv =====
// Shared types, constants and saturation helper for the tridiagonal solver.
package tts_pkg;
	localparam int DATA_W    = 32;
	localparam int ROW_IDX_W = 6;

	typedef struct packed {
		logic cap_in;
		logic drop;
		logic div_elim;
		logic take_m;
		logic mul_sup;
		logic sub_dia;
		logic sub_rhs;
		logic store;
		logic rd;
		logic bs_mul;
		logic bs_div;
		logic first;
		logic take_x;
		logic out_load;
		logic clr_fault;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} sts_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     ovf;
	} sat_t;

	function automatic sat_t sat32(input logic signed [64:0] v);
		sat_t r;
		r.ovf = 1'b0;
		if (v > 65'sh0_7FFF_FFFF) begin
			r.value = 32'sh7FFF_FFFF;
			r.ovf   = 1'b1;
		end else if (v < -65'sh0_8000_0000) begin
			r.value = 32'sh8000_0000;
			r.ovf   = 1'b1;
		end else begin
			r.value = v[DATA_W-1:0];
		end
		return r;
	endfunction
endpackage

// ===== rtl/tridiagonal_thomas_solver.sv =====
// Top level: Thomas algorithm tridiagonal solver, Q8.24 by default.
// Each row transaction runs from accept to accept: divider start, divider steps, done,
// multiply, two subtracts, store and the idle state that takes the row (row 0: take and store).
// Last row: back substitution for each row (RAM read, multiply, serial divide),
// then one solution at a time, held by output stalls. Rows are taken one at a time.
// Reset (arst_n low) clears the row count, fault flag and controller; the stores need no clear.
`include "tridiagonal_thomas_solver_macros.svh"
module tridiagonal_thomas_solver import tts_pkg::*; #(
	parameter int MAX_ROWS  = 64,
	parameter int FRAC_BITS = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     row_valid,
	output logic                     row_ready,
	input  logic signed [DATA_W-1:0] sub_coef,
	input  logic signed [DATA_W-1:0] diag_coef,
	input  logic signed [DATA_W-1:0] super_coef,
	input  logic signed [DATA_W-1:0] rhs_value,
	input  logic                     last_row,
	output logic                     sol_valid,
	input  logic                     sol_ready,
	output logic signed [DATA_W-1:0] solution,
	output logic [ROW_IDX_W-1:0]     row_index,
	output logic                     last_out,
	output logic                     divide_fault
);
	// Command and status between the sequencer and the arithmetic.
	cmd_t                        cmd;
	sts_t                        sts;
	logic [$clog2(MAX_ROWS)-1:0] addr;

	// Sequencer: counts rows, walks the index down for solve and readout.
	tts_ctrl #(.MAX_ROWS(MAX_ROWS)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.row_valid(row_valid), .row_ready(row_ready), .last_row(last_row),
		.sol_valid(sol_valid), .sol_ready(sol_ready),
		.sts(sts), .cmd(cmd), .addr(addr)
	);

	// Arithmetic: holds the previous row, the stores and the output register.
	tts_datapath #(.MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .addr(addr),
		.sub_coef(sub_coef), .diag_coef(diag_coef),
		.super_coef(super_coef), .rhs_value(rhs_value),
		.sts(sts), .solution(solution), .row_index(row_index),
		.last_out(last_out), .divide_fault(divide_fault)
	);

	// Rows are never taken while a solution is on offer.
	`TTS_ASSERT_IMP(a_no_overlap, sol_valid, !row_ready)
	// The row 0 flag matches the index.
	`TTS_ASSERT_IMP(a_last_idx, sol_valid, last_out == (row_index == '0))
	// After the final solution the block returns to taking rows.
	`TTS_ASSERT_NXT(a_end_idle, sol_valid && sol_ready && last_out, row_ready)
endmodule

// ===== rtl/tts_ram.sv =====
// Generic single write port, single registered read port RAM.
module tts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== rtl/tts_div.sv =====
// Restoring serial divider: (a << FRAC_BITS) / b, truncated, saturated to 32 bits.
module tts_div import tts_pkg::*; #(
	parameter int FRAC_BITS = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DATA_W-1:0] dividend,
	input  logic signed [DATA_W-1:0] divisor,
	output logic                     done,
	output logic signed [DATA_W-1:0] quotient,
	output logic                     fault
);
	localparam int W  = DATA_W + FRAC_BITS;
	localparam int QW = DATA_W + 1;

	logic              busy_q, done_q, zero_q, ovf_q, neg_q, a_neg_q;
	logic [QW-1:0]     dvd_q, quo_q;
	logic [DATA_W-1:0] rem_q, dsr_q;
	logic [5:0]        cnt_q;

	logic [DATA_W-1:0] mag_a, mag_b;
	logic [W-1:0]      d_full;
	logic [W-QW-1:0]   hi;
	logic [QW-1:0]     rem_sh;
	logic              ge;

	assign mag_a  = dividend[DATA_W-1] ? DATA_W'(-dividend) : dividend;
	assign mag_b  = divisor[DATA_W-1] ? DATA_W'(-divisor) : divisor;
	assign d_full = {mag_a, {FRAC_BITS{1'b0}}};
	assign hi     = d_full[W-1:QW];
	assign rem_sh = {rem_q, dvd_q[QW-1]};
	assign ge     = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (divisor == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= 6'(QW);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			zero_q  <= divisor == '0;
			a_neg_q <= dividend[DATA_W-1];
			neg_q   <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
			dsr_q   <= mag_b;
			rem_q   <= DATA_W'(hi);
			ovf_q   <= DATA_W'(hi) >= mag_b;
			dvd_q   <= d_full[QW-1:0];
			quo_q   <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DATA_W'(rem_sh - {1'b0, dsr_q}) : rem_sh[DATA_W-1:0];
			quo_q <= {quo_q[QW-2:0], ge};
			dvd_q <= {dvd_q[QW-2:0], 1'b0};
		end
	end

	always_comb begin
		fault    = 1'b0;
		quotient = '0;
		if (zero_q) begin
			fault    = 1'b1;
			quotient = a_neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else if (ovf_q || (neg_q ? quo_q > 33'h0_8000_0000 : quo_q > 33'h0_7FFF_FFFF)) begin
			fault    = 1'b1;
			quotient = neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			quotient = neg_q ? DATA_W'(-quo_q) : quo_q[DATA_W-1:0];
		end
	end

	assign done = done_q;
endmodule

// ===== rtl/tts_datapath.sv =====
// Datapath: input row registers, shared multiplier, saturating subtract, divider, stores.
module tts_datapath import tts_pkg::*; #(
	parameter int MAX_ROWS  = 64,
	parameter int FRAC_BITS = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cmd_t                            cmd,
	input  logic [$clog2(MAX_ROWS)-1:0]     addr,
	input  logic signed [DATA_W-1:0]        sub_coef,
	input  logic signed [DATA_W-1:0]        diag_coef,
	input  logic signed [DATA_W-1:0]        super_coef,
	input  logic signed [DATA_W-1:0]        rhs_value,
	output sts_t                            sts,
	output logic signed [DATA_W-1:0]        solution,
	output logic [ROW_IDX_W-1:0]            row_index,
	output logic                            last_out,
	output logic                            divide_fault
);
	logic signed [DATA_W-1:0] sub_q, dia_q, sup_q, rhs_q;
	logic signed [DATA_W-1:0] prev_dia_q, prev_sup_q, prev_rhs_q;
	logic signed [DATA_W-1:0] m_q, x_q;
	logic signed [63:0]       prod_s1, shifted;
	logic signed [DATA_W-1:0] dia_rd, sup_rd, rhs_rd;
	logic signed [DATA_W-1:0] mul_a, mul_b, sub_a;
	logic signed [DATA_W-1:0] div_a, div_b, div_q, t_val;
	logic                     div_done, div_fault, fault_q;
	logic signed [64:0]       diff;
	sat_t                     sat;
	logic                     rhs_we;
	logic [DATA_W-1:0]        rhs_wd;

	assign mul_a   = cmd.bs_mul ? sup_rd : m_q;
	assign mul_b   = cmd.bs_mul ? x_q : (cmd.mul_sup ? prev_sup_q : prev_rhs_q);
	assign shifted = prod_s1 >>> FRAC_BITS;
	assign sub_a   = cmd.sub_dia ? dia_q : (cmd.sub_rhs ? rhs_q : rhs_rd);
	assign diff    = {sub_a[DATA_W-1], {(64-DATA_W){sub_a[DATA_W-1]}}, sub_a}
		- {shifted[63], shifted};
	assign sat     = sat32(diff);
	assign t_val   = cmd.first ? rhs_rd : sat.value;
	assign div_a   = cmd.bs_div ? t_val : sub_q;
	assign div_b   = cmd.bs_div ? dia_rd : prev_dia_q;
	assign rhs_we  = cmd.store | cmd.take_x;
	assign rhs_wd  = cmd.take_x ? div_q : rhs_q;
	assign sts.div_done = div_done;

	tts_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_elim | cmd.bs_div),
		.dividend(div_a), .divisor(div_b),
		.done(div_done), .quotient(div_q), .fault(div_fault)
	);

	tts_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_dia_ram (
		.clk(clk), .we(cmd.store), .waddr(addr), .wdata(dia_q),
		.re(cmd.rd), .raddr(addr), .rdata(dia_rd)
	);
	tts_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_rhs_ram (
		.clk(clk), .we(rhs_we), .waddr(addr), .wdata(rhs_wd),
		.re(cmd.rd), .raddr(addr), .rdata(rhs_rd)
	);
	tts_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_sup_ram (
		.clk(clk), .we(cmd.store), .waddr(addr), .wdata(sup_q),
		.re(cmd.rd), .raddr(addr), .rdata(sup_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			sub_q <= sub_coef;
			dia_q <= diag_coef;
			sup_q <= super_coef;
			rhs_q <= rhs_value;
		end
		if (cmd.mul_sup || cmd.sub_dia || cmd.bs_mul) begin
			prod_s1 <= mul_a * mul_b;
		end
		if (cmd.sub_dia) begin
			dia_q <= sat.value;
		end
		if (cmd.sub_rhs) begin
			rhs_q <= sat.value;
		end
		if (cmd.take_m) begin
			m_q <= div_q;
		end
		if (cmd.take_x) begin
			x_q <= div_q;
		end
		if (cmd.store) begin
			prev_dia_q <= dia_q;
			prev_sup_q <= sup_q;
			prev_rhs_q <= rhs_q;
		end
		if (cmd.out_load) begin
			solution     <= rhs_rd;
			row_index    <= ROW_IDX_W'(addr);
			last_out     <= addr == '0;
			divide_fault <= fault_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_q <= 1'b0;
		end else if (cmd.clr_fault) begin
			fault_q <= 1'b0;
		end else if (cmd.drop || ((cmd.take_m || cmd.take_x) && div_fault)
				|| ((cmd.sub_dia || cmd.sub_rhs || (cmd.bs_div && !cmd.first)) && sat.ovf)) begin
			fault_q <= 1'b1;
		end
	end
endmodule

// ===== rtl/tts_ctrl.sv =====
// Controller: row count, row index and the sequencing of elimination, solve and readout.
module tts_ctrl import tts_pkg::*; #(
	parameter int MAX_ROWS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        row_valid,
	output logic                        row_ready,
	input  logic                        last_row,
	output logic                        sol_valid,
	input  logic                        sol_ready,
	input  sts_t                        sts,
	output cmd_t                        cmd,
	output logic [$clog2(MAX_ROWS)-1:0] addr
);
	localparam int AW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_ROWS + 1);

	typedef enum logic [13:0] {
		S_IDLE  = 14'b00000000000001,
		S_EDIV  = 14'b00000000000010,
		S_EWAIT = 14'b00000000000100,
		S_EMUL  = 14'b00000000001000,
		S_ESUBD = 14'b00000000010000,
		S_ESUBR = 14'b00000000100000,
		S_STORE = 14'b00000001000000,
		S_BRD   = 14'b00000010000000,
		S_BMUL  = 14'b00000100000000,
		S_BDIV  = 14'b00001000000000,
		S_BWAIT = 14'b00010000000000,
		S_ORD   = 14'b00100000000000,
		S_OLOAD = 14'b01000000000000,
		S_OVAL  = 14'b10000000000000
	} state_t;

	state_t         state_q, state_d;
	logic [CW-1:0]  rows_q, rows_d;
	logic [AW-1:0]  idx_q, idx_d;
	logic           last_q, last_d;
	logic           accept;

	assign accept    = row_valid && row_ready;
	assign row_ready = state_q == S_IDLE;
	assign sol_valid = state_q == S_OVAL;

	always_comb begin
		state_d = state_q;
		rows_d  = rows_q;
		idx_d   = idx_q;
		last_d  = last_q;
		cmd     = '0;
		addr    = idx_q;
		cmd.first = CW'(idx_q) == rows_q - CW'(1);
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.cap_in = 1'b1;
					last_d     = last_row;
					if (rows_q == CW'(MAX_ROWS)) begin
						cmd.drop = 1'b1;
						if (last_row) begin
							idx_d   = AW'(rows_q - CW'(1));
							state_d = S_BRD;
						end
					end else if (rows_q == '0) begin
						state_d = S_STORE;
					end else begin
						state_d = S_EDIV;
					end
				end
			end
			S_EDIV: begin
				cmd.div_elim = 1'b1;
				state_d      = S_EWAIT;
			end
			S_EWAIT: begin
				if (sts.div_done) begin
					cmd.take_m = 1'b1;
					state_d    = S_EMUL;
				end
			end
			S_EMUL: begin
				cmd.mul_sup = 1'b1;
				state_d     = S_ESUBD;
			end
			S_ESUBD: begin
				cmd.sub_dia = 1'b1;
				state_d     = S_ESUBR;
			end
			S_ESUBR: begin
				cmd.sub_rhs = 1'b1;
				state_d     = S_STORE;
			end
			S_STORE: begin
				cmd.store = 1'b1;
				addr      = rows_q[AW-1:0];
				rows_d    = rows_q + CW'(1);
				if (last_q) begin
					idx_d   = rows_q[AW-1:0];
					state_d = S_BRD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_BRD: begin
				cmd.rd  = 1'b1;
				state_d = S_BMUL;
			end
			S_BMUL: begin
				cmd.bs_mul = 1'b1;
				state_d    = S_BDIV;
			end
			S_BDIV: begin
				cmd.bs_div = 1'b1;
				state_d    = S_BWAIT;
			end
			S_BWAIT: begin
				if (sts.div_done) begin
					cmd.take_x = 1'b1;
					if (idx_q == '0) begin
						idx_d   = AW'(rows_q - CW'(1));
						state_d = S_ORD;
					end else begin
						idx_d   = idx_q - AW'(1);
						state_d = S_BRD;
					end
				end
			end
			S_ORD: begin
				cmd.rd  = 1'b1;
				state_d = S_OLOAD;
			end
			S_OLOAD: begin
				cmd.out_load = 1'b1;
				state_d      = S_OVAL;
			end
			S_OVAL: begin
				if (sol_ready) begin
					if (idx_q == '0) begin
						cmd.clr_fault = 1'b1;
						rows_d        = '0;
						state_d       = S_IDLE;
					end else begin
						idx_d   = idx_q - AW'(1);
						state_d = S_ORD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rows_q  <= '0;
			idx_q   <= '0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			rows_q  <= rows_d;
			idx_q   <= idx_d;
			last_q  <= last_d;
		end
	end
endmodule

// ===== tb/tridiagonal_thomas_solver_checker.sv =====
// Checker: watches both channels of the tridiagonal solver, predicts solutions and compares.
module tridiagonal_thomas_solver_checker import tts_pkg::*; #(
	parameter int MAX_ROWS  = 64,
	parameter int FRAC_BITS = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     row_valid,
	input  logic                     row_ready,
	input  logic signed [DATA_W-1:0] sub_coef,
	input  logic signed [DATA_W-1:0] diag_coef,
	input  logic signed [DATA_W-1:0] super_coef,
	input  logic signed [DATA_W-1:0] rhs_value,
	input  logic                     last_row,
	input  logic                     sol_valid,
	input  logic                     sol_ready,
	input  logic signed [DATA_W-1:0] solution,
	input  logic [ROW_IDX_W-1:0]     row_index,
	input  logic                     last_out,
	input  logic                     divide_fault,
	output int                       fail_count,
	output int                       pending
);
	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic [ROW_IDX_W-1:0]     idx;
		logic                     last;
		logic                     fault;
	} sol_t;

	logic signed [DATA_W-1:0] pivot_mem [MAX_ROWS];
	logic signed [DATA_W-1:0] rhs_mem   [MAX_ROWS];
	logic signed [DATA_W-1:0] upper_mem [MAX_ROWS];
	int   rows_held;
	bit   fault_acc;
	sol_t solution_q [$];

	function automatic longint clamp(input longint v);
		if (v > Q_MAX) begin
			fault_acc = 1'b1;
			return Q_MAX;
		end
		if (v < Q_MIN) begin
			fault_acc = 1'b1;
			return Q_MIN;
		end
		return v;
	endfunction

	// floor of the scaled product: arithmetic shift rounds toward minus infinity
	function automatic longint qmul(input longint a, input longint b);
		return (a * b) >>> FRAC_BITS;
	endfunction

	function automatic longint qdiv(input longint a, input longint b);
		if (b == 0) begin
			fault_acc = 1'b1;
			return (a >= 0) ? Q_MAX : Q_MIN;
		end
		return clamp((a * (64'sd1 <<< FRAC_BITS)) / b);
	endfunction

	task automatic eliminate_row(input longint sub, input longint dia, input longint sup,
		input longint rhs, input bit last);
		longint m, t;
		int n;
		sol_t s;
		if (rows_held >= MAX_ROWS) begin
			fault_acc = 1'b1;
		end else begin
			if (rows_held > 0) begin
				m   = qdiv(sub, pivot_mem[rows_held-1]);
				dia = clamp(dia - qmul(m, upper_mem[rows_held-1]));
				rhs = clamp(rhs - qmul(m, rhs_mem[rows_held-1]));
			end
			pivot_mem[rows_held] = DATA_W'(dia);
			rhs_mem[rows_held]   = DATA_W'(rhs);
			upper_mem[rows_held] = DATA_W'(sup);
			rows_held++;
		end
		if (!last)
			return;
		n = rows_held;
		rhs_mem[n-1] = DATA_W'(qdiv(rhs_mem[n-1], pivot_mem[n-1]));
		for (int i = n - 2; i >= 0; i--) begin
			t = clamp(longint'(rhs_mem[i]) - qmul(upper_mem[i], rhs_mem[i+1]));
			rhs_mem[i] = DATA_W'(qdiv(t, pivot_mem[i]));
		end
		for (int k = n - 1; k >= 0; k--) begin
			s.value = rhs_mem[k];
			s.idx   = ROW_IDX_W'(k);
			s.last  = (k == 0);
			s.fault = fault_acc;
			solution_q.push_back(s);
		end
		rows_held = 0;
		fault_acc = 1'b0;
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("MISMATCH %0s: got %0h expected %0h", what, got, want);
		fail_count++;
	endtask

	always @(posedge clk) begin
		sol_t e;
		if (!arst_n) begin
			fail_count = 0;
			pending    = 0;
			rows_held  = 0;
			fault_acc  = 1'b0;
			solution_q.delete();
		end else begin
			if (sol_valid && sol_ready) begin
				if (solution_q.size() == 0) begin
					report("unexpected solution", solution, 0);
				end else begin
					e = solution_q.pop_front();
					if (solution !== e.value)
						report("solution", solution, e.value);
					if (row_index !== e.idx)
						report("row_index", row_index, e.idx);
					if (last_out !== e.last)
						report("last_out", last_out, e.last);
					if (divide_fault !== e.fault)
						report("divide_fault", divide_fault, e.fault);
				end
			end
			if (row_valid && row_ready)
				eliminate_row(sub_coef, diag_coef, super_coef, rhs_value, last_row);
			pending = solution_q.size();
		end
	end
endmodule

// ===== tb/tridiagonal_thomas_solver_tb.sv =====
// Testbench top: drives row transactions into the tridiagonal solver and gives the verdict.
module tridiagonal_thomas_solver_tb import tts_pkg::*; ();

	localparam int ROW_TARGET    = 280;
	localparam int QUIET_FROM    = 235;   // no idling after this many rows
	localparam int CYCLE_CAP     = 600000;
	localparam int MAX_ROWS_FILL = 66;

	logic                     clk;
	logic                     arst_n;
	logic                     row_valid;
	logic                     row_ready;
	logic signed [DATA_W-1:0] sub_coef;
	logic signed [DATA_W-1:0] diag_coef;
	logic signed [DATA_W-1:0] super_coef;
	logic signed [DATA_W-1:0] rhs_value;
	logic                     last_row;
	logic                     sol_valid;
	logic                     sol_ready = 1'b0;
	logic signed [DATA_W-1:0] solution;
	logic [ROW_IDX_W-1:0]     row_index;
	logic                     last_out;
	logic                     divide_fault;
	int                       fail_count;
	int                       pending;
	int                       rows_sent;
	int                       cycle_count = 0;
	bit                       quiet;

	tridiagonal_thomas_solver dut (
		.clk(clk), .arst_n(arst_n),
		.row_valid(row_valid), .row_ready(row_ready),
		.sub_coef(sub_coef), .diag_coef(diag_coef), .super_coef(super_coef),
		.rhs_value(rhs_value), .last_row(last_row),
		.sol_valid(sol_valid), .sol_ready(sol_ready),
		.solution(solution), .row_index(row_index),
		.last_out(last_out), .divide_fault(divide_fault)
	);

	tridiagonal_thomas_solver_checker chk (
		.clk(clk), .arst_n(arst_n),
		.row_valid(row_valid), .row_ready(row_ready),
		.sub_coef(sub_coef), .diag_coef(diag_coef), .super_coef(super_coef),
		.rhs_value(rhs_value), .last_row(last_row),
		.sol_valid(sol_valid), .sol_ready(sol_ready),
		.solution(solution), .row_index(row_index),
		.last_out(last_out), .divide_fault(divide_fault),
		.fail_count(fail_count), .pending(pending)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("tridiagonal_thomas_solver verification failed");
			$finish;
		end
	end

	// Result side: stall in random bursts, then accept freely once quiet.
	always @(negedge clk) begin
		int burst;
		if (arst_n && !quiet && $urandom_range(0, 5) == 0) begin
			burst = $urandom_range(1, 18);
			sol_ready <= 1'b0;
			repeat (burst) @(negedge clk);
		end
		sol_ready <= 1'b1;
	end

	// Present one row transaction and hold it until accepted.
	// Drop valid for a random gap first, now and then.
	task automatic send_row(input logic [31:0] sub, input logic [31:0] dia,
		input logic [31:0] sup, input logic [31:0] rhs, input bit last);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			row_valid = 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		sub_coef   = sub;
		diag_coef  = dia;
		super_coef = sup;
		rhs_value  = rhs;
		last_row   = last;
		row_valid  = 1'b1;
		@(posedge clk);
		while (!row_ready)
			@(posedge clk);
		rows_sent++;
		quiet = (rows_sent >= QUIET_FROM);
	endtask

	// Well-conditioned rows: diagonal dominates sub and super, random sign.
	function automatic logic [31:0] small_coef(input int span);
		return 32'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic logic [31:0] pivot_coef();
		logic [31:0] v;
		v = $urandom_range(32'h0200_0000, 32'h0500_0000);
		return ($urandom_range(0, 1) != 0) ? -v : v;
	endfunction

	// Send a whole system of n rows; noisy rows carry arbitrary bit patterns.
	task automatic send_system(input int n, input int noise_pct);
		logic [31:0] a, b, c, d;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < noise_pct) begin
				a = $urandom; b = $urandom; c = $urandom; d = $urandom;
			end else begin
				a = small_coef(32'h0100_0000);
				b = pivot_coef();
				c = small_coef(32'h0100_0000);
				d = small_coef(32'h0400_0000);
			end
			send_row(a, b, c, d, i == n - 1);
		end
	endtask

	initial begin
		int n;
		arst_n      = 1'b0;
		row_valid   = 1'b0;
		sub_coef    = '0;
		diag_coef   = '0;
		super_coef  = '0;
		rhs_value   = '0;
		last_row    = 1'b0;
		rows_sent   = 0;
		quiet       = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// single-row system, plain and with a zero divisor
		send_row(32'h0, 32'h0200_0000, 32'h0, 32'h0300_0000, 1'b1);
		send_row(32'h0, 32'h0, 32'h0, 32'hFF00_0000, 1'b1);
		send_row(32'h0, 32'h0, 32'h0, 32'h0100_0000, 1'b1);
		// field extremes: overflowing quotients and products
		send_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		send_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		send_row(32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
		// zero modified diagonal in the middle of a system
		send_row(32'h0, 32'h0, 32'h0100_0000, 32'h0100_0000, 1'b0);
		send_row(32'h0100_0000, 32'h0100_0000, 32'h0, 32'hFFFF_FFFF, 1'b1);
		// small clean system
		send_system(4, 0);
		// store full: rows beyond the limit are dropped, the last one still solves
		send_system(MAX_ROWS_FILL, 0);

		while (rows_sent < ROW_TARGET) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			if (n > ROW_TARGET - rows_sent && rows_sent > QUIET_FROM)
				n = ROW_TARGET - rows_sent + 1;
			send_system(n, ($urandom_range(0, 3) == 0) ? 60 : 5);
		end

		@(negedge clk);
		row_valid = 1'b0;
		last_row  = 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("tridiagonal_thomas_solver verification clean");
		else
			$display("tridiagonal_thomas_solver verification failed");
		$finish;
	end
endmodule
